/* rtl/ppmu_pkg.sv */
// Shared types, constants and the arctangent table for the particle pose
// motion update pipeline. No dependencies.
`default_nettype none
package ppmu_pkg;

   localparam int XW = 49;              // CORDIC x/y datapath, Q17.32 plus headroom
   localparam int ZW = 33;              // CORDIC residual angle
   localparam int CSR_AW = 2;
   localparam int MAX_STAGES = 32;

   localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

   localparam logic [CSR_AW-1:0] CSR_STEP_DISTANCE  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_STEP_DIRECTION = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_STEP_TURN      = 2'd2;

   typedef struct packed {
      logic [30:0] step_distance;
      logic [31:0] step_direction;
      logic [31:0] step_turn;
   } cfg_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic signed [31:0]   pos_x;
      logic signed [31:0]   pos_y;
      logic signed [31:0]   new_heading;
   } cordic_type;

   function automatic logic [31:0] atan_angle(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         5'd31: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/ppmu_intf.sv */
// Valid/ready channel interfaces: pose requests, pose responses and the
// register write port. Depends on ppmu_pkg for the register index width.
`default_nettype none
interface ppmu_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] heading;
   modport source (output valid, pos_x, pos_y, heading, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface ppmu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic signed [31:0] new_heading;
   modport source (output valid, new_x, new_y, new_heading, input ready);
   modport sink   (input valid, new_x, new_y, new_heading, output ready);
endinterface

interface ppmu_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ppmu_pkg::CSR_AW-1:0]      addr;
   logic [31:0]                      data;
   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

/* rtl/ppmu_csr.sv */
// Step registers (distance, direction, turn) behind the write channel.
// Depends on ppmu_pkg.
`default_nettype none
module ppmu_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_valid,
   output logic                        wr_ready,
   input  logic [ppmu_pkg::CSR_AW-1:0] wr_addr,
   input  logic [31:0]                 wr_data,
   output ppmu_pkg::cfg_type           cfg
);
   ppmu_pkg::cfg_type cfg_ff;
   ppmu_pkg::cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (wr_addr)
            ppmu_pkg::CSR_STEP_DISTANCE:  cfg_in.step_distance  = wr_data[30:0];
            ppmu_pkg::CSR_STEP_DIRECTION: cfg_in.step_direction = wr_data;
            ppmu_pkg::CSR_STEP_TURN:      cfg_in.step_turn      = wr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/ppmu_front.sv */
// Front end: travel angle, quadrant fold, gain multiply (stage A) and
// signed start vector (stage B). Depends on ppmu_pkg.
`default_nettype none
module ppmu_front (
   input  logic                    clock,
   input  logic                    reset,
   input  ppmu_pkg::cfg_type       cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [31:0]      pos_x,
   input  logic signed [31:0]      pos_y,
   input  logic signed [31:0]      heading,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ppmu_pkg::cordic_type    out_data
);
   logic                         a_valid_ff;
   logic                         a_ready;
   logic                         a_neg_ff;
   logic                         a_neg_in;
   logic signed [ppmu_pkg::ZW-1:0] a_z_ff;
   logic signed [ppmu_pkg::ZW-1:0] a_z_in;
   logic [62:0]                  a_prod_ff;
   logic [62:0]                  a_prod_in;
   logic signed [31:0]           a_px_ff;
   logic signed [31:0]           a_py_ff;
   logic signed [31:0]           a_nh_ff;
   logic signed [31:0]           a_nh_in;
   logic [31:0]                  ang;
   logic [31:0]                  zbits;

   logic                         b_valid_ff;
   logic                         b_ready;
   ppmu_pkg::cordic_type         b_data_ff;
   ppmu_pkg::cordic_type         b_data_in;
   logic signed [ppmu_pkg::XW-1:0] mag;

   assign a_ready  = !a_valid_ff || b_ready;
   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = a_ready;

   // quadrants 1 and 2 start from the negated vector, angle folded by a half turn
   always_comb begin
      ang       = heading + cfg.step_direction;
      a_neg_in  = ang[31] ^ ang[30];
      zbits     = {ang[31] ^ a_neg_in, ang[30:0]};
      a_z_in    = {zbits[31], zbits};
      a_prod_in = 63'(cfg.step_distance) * 63'(ppmu_pkg::GAIN_Q32);
      a_nh_in   = heading + cfg.step_turn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_neg_ff  <= a_neg_in;
         a_z_ff    <= a_z_in;
         a_prod_ff <= a_prod_in;
         a_px_ff   <= pos_x;
         a_py_ff   <= pos_y;
         a_nh_ff   <= a_nh_in;
      end
   end

   always_comb begin
      mag                   = {2'b00, a_prod_ff[62:16]};
      b_data_in.x           = a_neg_ff ? -mag : mag;
      b_data_in.y           = '0;
      b_data_in.z           = a_z_ff;
      b_data_in.pos_x       = a_px_ff;
      b_data_in.pos_y       = a_py_ff;
      b_data_in.new_heading = a_nh_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;
endmodule
`default_nettype wire

/* rtl/ppmu_rot.sv */
// One registered CORDIC rotation stage, shift and arctangent fixed by
// STAGE_IDX. Depends on ppmu_pkg.
`default_nettype none
module ppmu_rot #(
   parameter int STAGE_IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ppmu_pkg::cordic_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ppmu_pkg::cordic_type out_data
);
   localparam logic [31:0] ATAN = ppmu_pkg::atan_angle(5'(STAGE_IDX));

   logic                           valid_ff;
   ppmu_pkg::cordic_type           data_ff;
   ppmu_pkg::cordic_type           data_in;
   logic signed [ppmu_pkg::XW-1:0] xs;
   logic signed [ppmu_pkg::XW-1:0] ys;
   logic signed [ppmu_pkg::ZW-1:0] da;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      xs      = in_data.x >>> STAGE_IDX;
      ys      = in_data.y >>> STAGE_IDX;
      da      = {1'b0, ATAN};
      data_in = in_data;
      if (!in_data.z[ppmu_pkg::ZW-1]) begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - da;
      end else begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

/* rtl/ppmu_back.sv */
// Back end: rounding of the rotated vector to Q16.16 (stage R) and the
// saturating position add into the response register. Depends on ppmu_pkg.
`default_nettype none
module ppmu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ppmu_pkg::cordic_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [31:0]   new_x,
   output logic signed [31:0]   new_y,
   output logic signed [31:0]   new_heading
);
   logic                           r_valid_ff;
   logic                           r_ready;
   logic signed [32:0]             r_dx_ff;
   logic signed [32:0]             r_dy_ff;
   logic signed [31:0]             r_px_ff;
   logic signed [31:0]             r_py_ff;
   logic signed [31:0]             r_nh_ff;
   logic signed [ppmu_pkg::XW-1:0] rx;
   logic signed [ppmu_pkg::XW-1:0] ry;
   logic signed [ppmu_pkg::XW-1:0] half;

   logic                           s_valid_ff;
   logic                           s_ready;
   logic signed [33:0]             sx;
   logic signed [33:0]             sy;
   logic signed [31:0]             s_x_ff;
   logic signed [31:0]             s_x_in;
   logic signed [31:0]             s_y_ff;
   logic signed [31:0]             s_y_in;
   logic signed [31:0]             s_nh_ff;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
      logic signed [31:0] r;
      if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
         r = s[31:0];
      end else if (s[33]) begin
         r = 32'sh80000000;
      end else begin
         r = 32'sh7FFFFFFF;
      end
      return r;
   endfunction

   assign r_ready  = !r_valid_ff || s_ready;
   assign s_ready  = !s_valid_ff || out_ready;
   assign in_ready = r_ready;

   always_comb begin
      half = ppmu_pkg::XW'(32768);
      rx   = (in_data.x + half) >>> 16;
      ry   = (in_data.y + half) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (r_ready) begin
         r_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (r_ready && in_valid) begin
         r_dx_ff <= rx[32:0];
         r_dy_ff <= ry[32:0];
         r_px_ff <= in_data.pos_x;
         r_py_ff <= in_data.pos_y;
         r_nh_ff <= in_data.new_heading;
      end
   end

   always_comb begin
      sx     = {{2{r_px_ff[31]}}, r_px_ff} + {r_dx_ff[32], r_dx_ff};
      sy     = {{2{r_py_ff[31]}}, r_py_ff} + {r_dy_ff[32], r_dy_ff};
      s_x_in = sat32(sx);
      s_y_in = sat32(sy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (s_ready) begin
         s_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s_ready && r_valid_ff) begin
         s_x_ff  <= s_x_in;
         s_y_ff  <= s_y_in;
         s_nh_ff <= r_nh_ff;
      end
   end

   assign out_valid   = s_valid_ff;
   assign new_x       = s_x_ff;
   assign new_y       = s_y_ff;
   assign new_heading = s_nh_ff;
endmodule
`default_nettype wire

/* rtl/particle_pose_motion_update_unit.sv */
// Particle pose motion update: applies the programmed odometry step
// (distance, direction, turn) to each particle pose beat on req_ch and
// returns the moved pose on rsp_ch, one response per request, in order.
// Throughput is one pose per clock while rsp_ch accepts responses; the
// pipeline holds two front stages, one register per CORDIC rotation, and
// the rounding and saturation stages. Every stage has its own valid bit,
// so empty stages keep filling while a response waits. Register writes
// on csr_ch are always ready; write them only while no pose is in flight.
// Depends on ppmu_pkg, ppmu_intf, ppmu_csr, ppmu_front, ppmu_rot,
// ppmu_back.
`default_nettype none
module particle_pose_motion_update_unit #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic        clock,
   input  logic        reset,
   ppmu_req_if.sink    req_ch,
   ppmu_rsp_if.source  rsp_ch,
   ppmu_csr_if.sink    csr_ch
);
   localparam int NUM = (CORDIC_STAGES > ppmu_pkg::MAX_STAGES) ?
                        ppmu_pkg::MAX_STAGES : CORDIC_STAGES;

   ppmu_pkg::cfg_type    cfg;
   logic                 pv    [NUM+1];
   logic                 pr    [NUM+1];
   ppmu_pkg::cordic_type pd    [NUM+1];

   ppmu_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_ready (csr_ch.ready),
      .wr_addr  (csr_ch.addr),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   ppmu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .pos_x     (req_ch.pos_x),
      .pos_y     (req_ch.pos_y),
      .heading   (req_ch.heading),
      .out_valid (pv[0]),
      .out_ready (pr[0]),
      .out_data  (pd[0])
   );

   for (genvar i = 0; i < NUM; i++) begin : g_rot
      ppmu_rot #(
         .STAGE_IDX (i)
      ) u_rot (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pv[i]),
         .in_ready  (pr[i]),
         .in_data   (pd[i]),
         .out_valid (pv[i+1]),
         .out_ready (pr[i+1]),
         .out_data  (pd[i+1])
      );
   end

   ppmu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pv[NUM]),
      .in_ready    (pr[NUM]),
      .in_data     (pd[NUM]),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .new_x       (rsp_ch.new_x),
      .new_y       (rsp_ch.new_y),
      .new_heading (rsp_ch.new_heading)
   );
endmodule
`default_nettype wire

/* verif/ppmu_motion_checker.sv */
// Checker for the particle pose motion update unit: tracks register writes,
// predicts each moved pose from the accepted request beats and compares the
// response beats in order. Depends on ppmu_pkg and ppmu_intf.
module ppmu_motion_checker #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic clock,
   input  logic reset,
   ppmu_req_if  req_ch,
   ppmu_rsp_if  rsp_ch,
   ppmu_csr_if  csr_ch,
   output int   error_count,
   output int   pending_count
);

   localparam int ROT_STAGES = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam logic [63:0] CORDIC_GAIN = 64'h0000_0000_9B74_EDA8;
   localparam longint POS_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint POS_MIN = 64'shFFFF_FFFF_8000_0000;

   // atan(2^-i) as binary angles, full turn 2^32
   localparam logic [31:0] ARCTAN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] heading;
   } pose_type;

   logic [30:0] dist_q;
   logic [31:0] dir_q;
   logic [31:0] turn_q;
   pose_type    moves_due [$];

   function automatic logic signed [31:0] clamp_add(logic signed [31:0] pos, longint delta);
      longint s;
      s = longint'(pos) + delta;
      if (s > POS_MAX) return 32'h7FFF_FFFF;
      if (s < POS_MIN) return 32'h8000_0000;
      return s[31:0];
   endfunction

   function automatic pose_type move_pose(pose_type p);
      pose_type    m;
      logic [31:0] travel;
      logic [63:0] scaled;
      longint      x, y, z, xs, ys;
      travel = p.heading + dir_q;
      scaled = {33'd0, dist_q} * CORDIC_GAIN;
      x = longint'(scaled >> 16);
      y = 0;
      // rear half plane: start from the negated vector, half a turn back
      if (travel[31:30] == 2'b01 || travel[31:30] == 2'b10) begin
         x = -x;
         z = longint'($signed(travel ^ 32'h8000_0000));
      end else begin
         z = longint'($signed(travel));
      end
      for (int i = 0; i < ROT_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(ARCTAN[i]);
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(ARCTAN[i]);
         end
      end
      m.x = clamp_add(p.x, (x + 32768) >>> 16);
      m.y = clamp_add(p.y, (y + 32768) >>> 16);
      m.heading = p.heading + turn_q;
      return m;
   endfunction

   task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dist_q = '0;
         dir_q = '0;
         turn_q = '0;
         moves_due.delete();
         error_count = 0;
         pending_count <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (moves_due.size() == 0) begin
               $error("response beat with no pose pending");
               error_count++;
            end else begin
               check_field("new_x", moves_due[0].x, rsp_ch.new_x);
               check_field("new_y", moves_due[0].y, rsp_ch.new_y);
               check_field("new_heading", moves_due[0].heading, rsp_ch.new_heading);
               void'(moves_due.pop_front());
            end
         end
         if (req_ch.valid && req_ch.ready)
            moves_due.push_back(move_pose({req_ch.pos_x, req_ch.pos_y, req_ch.heading}));
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.addr)
               ppmu_pkg::CSR_STEP_DISTANCE:  dist_q = csr_ch.data[30:0];
               ppmu_pkg::CSR_STEP_DIRECTION: dir_q = csr_ch.data;
               ppmu_pkg::CSR_STEP_TURN:      turn_q = csr_ch.data;
               default: ;
            endcase
         end
         pending_count <= moves_due.size();
      end
   end

endmodule

/* verif/particle_pose_motion_update_unit_tb.sv */
// Testbench top for particle_pose_motion_update_unit: clock, reset, pose and
// register stimulus, response back-pressure, watchdog and verdict.
// Depends on ppmu_pkg, ppmu_intf, the unit itself and ppmu_motion_checker.
module particle_pose_motion_update_unit_tb;

   localparam int STAGES = 24;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 70;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam logic [ppmu_pkg::CSR_AW-1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic steady;
   logic hold_rsp;
   int   error_count;
   int   pending_count;
   int   quiet_cycles;

   ppmu_req_if req_ch ();
   ppmu_rsp_if rsp_ch ();
   ppmu_csr_if csr_ch ();

   particle_pose_motion_update_unit #(.CORDIC_STAGES(STAGES)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ppmu_motion_checker #(.CORDIC_STAGES(STAGES)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #2 clock = ~clock;

   // response back-pressure, with one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= 31);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("particle_pose_motion_update_unit_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [31:0] pick_coord();
      if ($urandom_range(3) == 0)
         return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(32'h3_FFFF)
                                  : 32'h8000_0000 + $urandom_range(32'h3_FFFF);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_angle();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'h4000_0000;
         4: return 32'hC000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_distance();
      case ($urandom_range(3))
         0: return 32'h0;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(32'h00FF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   // holds valid high after the beat; the caller lowers it
   task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [31:0] hd);
      while (!steady && $urandom_range(99) < 31) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pos_x <= px;
      req_ch.pos_y <= py;
      req_ch.heading <= hd;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random_pose();
      send_pose(pick_coord(), pick_coord(), $urandom);
   endtask

   task automatic write_reg(logic [ppmu_pkg::CSR_AW-1:0] idx, logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.addr <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic program_step(logic [31:0] dist_val, logic [31:0] dir, logic [31:0] turn);
      write_reg(ppmu_pkg::CSR_STEP_DISTANCE, dist_val);
      write_reg(ppmu_pkg::CSR_STEP_DIRECTION, dir);
      write_reg(ppmu_pkg::CSR_STEP_TURN, turn);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      logic [31:0] dist_val, dir, turn;
      reset = 1'b1;
      steady = 1'b0;
      hold_rsp = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.heading = '0;
      csr_ch.valid = 1'b0;
      csr_ch.addr = '0;
      csr_ch.data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero step after reset: positions pass through, heading unchanged
      send_pose(32'h0, 32'h0, 32'h0);
      send_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      drain();

      // spare index is ignored; distance bit 31 is dropped
      write_reg(CSR_SPARE, 32'hFFFF_FFFF);
      program_step(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
      send_pose(32'h0, 32'h0, 32'h0000_0000);
      send_pose(32'h0, 32'h0, 32'h3FFF_FFFF);
      send_pose(32'h0, 32'h0, 32'h4000_0000);
      send_pose(32'h0, 32'h0, 32'h7FFF_FFFF);
      send_pose(32'h0, 32'h0, 32'h8000_0000);
      send_pose(32'h0, 32'h0, 32'hBFFF_FFFF);
      send_pose(32'h0, 32'h0, 32'hC000_0000);
      send_pose(32'h0, 32'h0, 32'hFFFF_FFFF);
      // saturation on each edge of the position range
      send_pose(32'h7FFF_FFFF, 32'h0, 32'h0000_0000);
      send_pose(32'h8000_0000, 32'h0, 32'h8000_0000);
      send_pose(32'h0, 32'h7FFF_FFFF, 32'h4000_0000);
      send_pose(32'h0, 32'h8000_0000, 32'hC000_0000);
      drain();

      program_step(32'h1, 32'h8000_0000, 32'h8000_0000);
      send_pose(32'h0, 32'h0, 32'h0);
      send_pose(32'h1234_5678, 32'hEDCB_A988, 32'h4000_0000);
      send_pose(32'hFFFF_FFFF, 32'h0000_0001, 32'hC000_0001);

      // stall the response side long enough to fill the pipeline
      hold_rsp = 1'b1;
      steady = 1'b1;
      repeat (60) send_random_pose();
      steady = 1'b0;
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0) begin
            dist_val = 32'h7FFF_FFFF;
            dir = 32'h7FFF_FFFF;
            turn = 32'h8000_0000;
         end else if (ph == 1) begin
            dist_val = 32'h0;
            dir = 32'h8000_0000;
            turn = 32'h7FFF_FFFF;
         end else begin
            dist_val = pick_distance();
            dir = pick_angle();
            turn = pick_angle();
         end
         program_step(dist_val, dir, turn);
         steady = (ph == 2);
         repeat (PHASE_ITEMS) send_random_pose();
         drain();
      end
      steady = 1'b0;

      repeat (STAGES + 8) @(posedge clock);
      if (error_count == 0)
         $display("particle_pose_motion_update_unit_tb: done, clean");
      else
         $display("particle_pose_motion_update_unit_tb: done, errors");
      $finish;
   end

endmodule
